// ----- sv/lapt_pkg.sv -----
package lapt_pkg;

	localparam int SQRT_STEPS = 20;
	localparam int ANG_W = 27;
	localparam int VEC_W = 40;
	localparam int ARG_W = 22;
	localparam logic signed [ANG_W-1:0] DEG90 = 27'sd5898240;
	localparam logic signed [27:0] DEG180 = 28'sd11796480;
	localparam logic signed [18:0] PAN_MAX = 19'sd46080;

	typedef enum logic [1:0] {
		REG_NECK_HEIGHT = 2'd0,
		REG_EYE_OFFSET  = 2'd1,
		REG_TILT_LIMIT  = 2'd2,
		REG_NONE        = 2'd3
	} cfg_reg_t;

	function automatic logic [21:0] atan_coef(input int i);
		logic [21:0] v;
		unique case (i)
			0: v = 22'd2949120;
			1: v = 22'd1740967;
			2: v = 22'd919879;
			3: v = 22'd466945;
			4: v = 22'd234379;
			5: v = 22'd117304;
			6: v = 22'd58666;
			7: v = 22'd29335;
			8: v = 22'd14668;
			9: v = 22'd7334;
			10: v = 22'd3667;
			11: v = 22'd1833;
			12: v = 22'd917;
			13: v = 22'd458;
			14: v = 22'd229;
			15: v = 22'd115;
			16: v = 22'd57;
			17: v = 22'd29;
			18: v = 22'd14;
			19: v = 22'd7;
			20: v = 22'd4;
			21: v = 22'd2;
			22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- sv/lapt_isqrt.sv -----
module lapt_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [39:0] radicand,
	output logic [19:0] root
);

	logic [39:0] rem_s [0:lapt_pkg::SQRT_STEPS];
	logic [40:0] res_s [0:lapt_pkg::SQRT_STEPS];

	assign rem_s[0] = radicand;
	assign res_s[0] = '0;

	for (genvar k = 0; k < lapt_pkg::SQRT_STEPS; k++) begin : g_step
		localparam logic [40:0] BIT = 41'd1 << (2 * (lapt_pkg::SQRT_STEPS - 1 - k));
		logic [40:0] trial;
		assign trial = res_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_s[k]} >= trial) begin
					rem_s[k+1] <= rem_s[k] - trial[39:0];
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1] <= rem_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign root = res_s[lapt_pkg::SQRT_STEPS][19:0];

endmodule

// ----- sv/lapt_cordic.sv -----
module lapt_cordic #(
	parameter int ITER = 16
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [lapt_pkg::ARG_W-1:0]      px,
	input  logic signed [lapt_pkg::ARG_W-1:0]      py,
	output logic signed [lapt_pkg::ANG_W-1:0]      angle
);

	logic signed [lapt_pkg::VEC_W-1:0] cx_s [0:ITER];
	logic signed [lapt_pkg::VEC_W-1:0] cy_s [0:ITER];
	logic signed [lapt_pkg::ANG_W-1:0] cz_s [0:ITER];
	logic                              zf_s [0:ITER];
	logic signed [lapt_pkg::VEC_W-1:0] x0, y0;

	assign x0 = {{2{px[lapt_pkg::ARG_W-1]}}, px, 16'b0};
	assign y0 = {{2{py[lapt_pkg::ARG_W-1]}}, py, 16'b0};

	// quadrant fold
	always_ff @(posedge clk) begin
		if (en) begin
			zf_s[0] <= (px == '0) && (py == '0);
			if (x0 < 0) begin
				if (y0 >= 0) begin
					cx_s[0] <= y0;
					cy_s[0] <= -x0;
					cz_s[0] <= lapt_pkg::DEG90;
				end else begin
					cx_s[0] <= -y0;
					cy_s[0] <= x0;
					cz_s[0] <= -lapt_pkg::DEG90;
				end
			end else begin
				cx_s[0] <= x0;
				cy_s[0] <= y0;
				cz_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_iter
		localparam logic signed [lapt_pkg::ANG_W-1:0] ATN =
			$signed({5'b0, lapt_pkg::atan_coef(i)});
		logic signed [lapt_pkg::VEC_W-1:0] dx, dy;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				zf_s[i+1] <= zf_s[i];
				if (cy_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cz_s[i] + ATN;
				end else begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cz_s[i] - ATN;
				end
			end
		end
	end

	assign angle = zf_s[ITER] ? '0 : cz_s[ITER];

endmodule

// ----- sv/look_at_pan_tilt_angles_unit.sv -----
// channel   signals                                            dir
// in        in_valid, in_stall, target_x/y/z                   request in
// out       out_valid, out_stall, pan_angle, tilt_angle,       request out
//           tilt_clamped, domain_error
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data          write in
//
// one request per cycle while out_stall does not freeze the pipeline; stages in order:
// 4 square/sum stages, 20 square-root steps, fold + CORDIC stages, output
// arst_n clears the valid bits and loads the register reset values
// out_stall with a valid result freezes the whole pipeline; empty output takes input
module look_at_pan_tilt_angles_unit #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [19:0] target_x,
	input  logic signed [19:0] target_y,
	input  logic signed [19:0] target_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] pan_angle,
	output logic signed [16:0] tilt_angle,
	output logic               tilt_clamped,
	output logic               domain_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data
);

	localparam int SQ = lapt_pkg::SQRT_STEPS;
	localparam int CL = CORDIC_ITERATIONS + 1;
	localparam int LAT = 4 + SQ + CL + 1;

	logic [15:0]        neck_q;
	logic [11:0]        eye_q;
	logic signed [16:0] limit_q;
	logic               en;
	logic [LAT-1:0]     vld_s;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neck_q  <= 16'd11300;
			eye_q   <= 12'd480;
			limit_q <= -17'sd12032;
		end else if (cfg_valid) begin
			unique case (lapt_pkg::cfg_reg_t'(cfg_index))
				lapt_pkg::REG_NECK_HEIGHT: neck_q  <= cfg_data[15:0];
				lapt_pkg::REG_EYE_OFFSET:  eye_q   <= cfg_data[11:0];
				lapt_pkg::REG_TILT_LIMIT:  limit_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign en = !(vld_s[LAT-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	// squares and sums
	logic signed [19:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic signed [39:0] xx_s1, yy_s1;
	logic signed [21:0] h_s1, h_s2, h_s3, h_s4;
	logic [39:0]        r2_s2, h2_s2, r2_s3, d2_s3, r2_s4, sq_s4;
	logic [23:0]        e2_s3;
	logic               dom_s4;
	logic signed [43:0] hh;

	assign hh = h_s1 * h_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= target_x;
			y_s1  <= target_y;
			xx_s1 <= target_x * target_x;
			yy_s1 <= target_y * target_y;
			h_s1  <= $signed({6'b0, neck_q}) - {{2{target_z[19]}}, target_z};
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			h_s2  <= h_s1;
			r2_s2 <= xx_s1[39:0] + yy_s1[39:0];
			h2_s2 <= hh[39:0];
			x_s3  <= x_s2;
			y_s3  <= y_s2;
			h_s3  <= h_s2;
			r2_s3 <= r2_s2;
			d2_s3 <= r2_s2 + h2_s2;
			e2_s3 <= eye_q * eye_q;
			x_s4  <= x_s3;
			y_s4  <= y_s3;
			h_s4  <= h_s3;
			r2_s4 <= r2_s3;
			dom_s4 <= !(d2_s3 > {16'b0, e2_s3});
			sq_s4 <= (d2_s3 > {16'b0, e2_s3}) ? d2_s3 - {16'b0, e2_s3} : '0;
		end
	end

	// square roots, with side data delayed alongside
	logic [19:0] r_root, s_root;

	lapt_isqrt u_sqrt_r (.clk(clk), .en(en), .radicand(r2_s4), .root(r_root));
	lapt_isqrt u_sqrt_s (.clk(clk), .en(en), .radicand(sq_s4), .root(s_root));

	logic signed [19:0] xd_q [0:SQ-1];
	logic signed [19:0] yd_q [0:SQ-1];
	logic signed [21:0] hd_q [0:SQ-1];
	logic               domd_q [0:SQ+CL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			xd_q[0]   <= x_s4;
			yd_q[0]   <= y_s4;
			hd_q[0]   <= h_s4;
			domd_q[0] <= dom_s4;
			for (int k = 1; k < SQ; k++) begin
				xd_q[k] <= xd_q[k-1];
				yd_q[k] <= yd_q[k-1];
				hd_q[k] <= hd_q[k-1];
			end
			for (int k = 1; k < SQ + CL; k++) begin
				domd_q[k] <= domd_q[k-1];
			end
		end
	end

	// angles
	logic signed [lapt_pkg::ANG_W-1:0] pan_z, alpha_z, beta_z;

	lapt_cordic #(.ITER(CORDIC_ITERATIONS)) u_pan (
		.clk(clk), .en(en),
		.px({{2{xd_q[SQ-1][19]}}, xd_q[SQ-1]}),
		.py({{2{yd_q[SQ-1][19]}}, yd_q[SQ-1]}),
		.angle(pan_z)
	);

	lapt_cordic #(.ITER(CORDIC_ITERATIONS)) u_alpha (
		.clk(clk), .en(en),
		.px(hd_q[SQ-1]),
		.py({2'b0, r_root}),
		.angle(alpha_z)
	);

	lapt_cordic #(.ITER(CORDIC_ITERATIONS)) u_beta (
		.clk(clk), .en(en),
		.px({10'b0, eye_q}),
		.py({2'b0, s_root}),
		.angle(beta_z)
	);

	// rounding, saturation and clamp
	logic signed [lapt_pkg::ANG_W-1:0] pan_rnd;
	logic signed [18:0]                pan_deg;
	logic signed [27:0]                tilt_sum;
	logic signed [19:0]                tilt_deg;
	logic                              dom_end;

	assign dom_end  = domd_q[SQ+CL-1];
	assign pan_rnd  = (pan_z + 27'sd128) >>> 8;
	assign pan_deg  = pan_rnd[18:0];
	assign tilt_sum = ({alpha_z[lapt_pkg::ANG_W-1], alpha_z}
		+ (dom_end ? 28'sd0 : {beta_z[lapt_pkg::ANG_W-1], beta_z})
		- lapt_pkg::DEG180 + 28'sd128) >>> 8;
	assign tilt_deg = tilt_sum[19:0];

	always_ff @(posedge clk) begin
		if (en) begin
			if (pan_deg > lapt_pkg::PAN_MAX) begin
				pan_angle <= 17'sd46080;
			end else if (pan_deg < -lapt_pkg::PAN_MAX) begin
				pan_angle <= -17'sd46080;
			end else begin
				pan_angle <= pan_deg[16:0];
			end
			if (tilt_deg < $signed({{3{limit_q[16]}}, limit_q})) begin
				tilt_angle   <= limit_q;
				tilt_clamped <= 1'b1;
			end else begin
				tilt_angle   <= tilt_deg[16:0];
				tilt_clamped <= 1'b0;
			end
			domain_error <= dom_end;
		end
	end

endmodule

// ----- tb/look_at_pan_tilt_angles_unit_test.sv -----
`timescale 1ns / 100ps

module look_at_pan_tilt_angles_unit_test;

	localparam int N_ITER = 16;
	localparam int PIPE_LAT = 26 + N_ITER;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic signed [16:0] pan;
		logic signed [16:0] tilt;
		logic               clamped;
		logic               dom_err;
	} angles_t;

	localparam longint ATAN_FINE [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [19:0] target_x = 0;
	logic signed [19:0] target_y = 0;
	logic signed [19:0] target_z = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [16:0] pan_angle;
	logic signed [16:0] tilt_angle;
	logic               tilt_clamped;
	logic               domain_error;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = 0;
	logic [16:0]        cfg_data = 0;

	look_at_pan_tilt_angles_unit #(.CORDIC_ITERATIONS(N_ITER)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.pan_angle(pan_angle), .tilt_angle(tilt_angle),
		.tilt_clamped(tilt_clamped), .domain_error(domain_error),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// register copies
	longint neck_h = 11300;
	longint eye_off = 480;
	longint tilt_floor = -12032;

	angles_t expected_angles[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_clamped = 0;
	int n_domain = 0;
	int cycles = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int burst_left = 0;
	int gap_max = 0;

	function automatic longint vector_angle(longint py, longint px);
		longint vx, vy, za, t, dx, dy;
		za = 0;
		if (px == 0 && py == 0)
			return 0;
		vx = px * 65536;
		vy = py * 65536;
		if (vx < 0) begin
			if (vy >= 0) begin
				t = vx; vx = vy; vy = -t; za = 90 * 65536;
			end else begin
				t = vx; vx = -vy; vy = t; za = -90 * 65536;
			end
		end
		for (int i = 0; i < N_ITER && i < 24; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx; vy -= dy; za += ATAN_FINE[i];
			end else begin
				vx -= dx; vy += dy; za -= ATAN_FINE[i];
			end
		end
		return za;
	endfunction

	function automatic longint int_sqrt(longint n);
		longint root, b;
		root = 0;
		b = 64'sd1 <<< 62;
		while (b > n)
			b = b >>> 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >>> 1) + b;
			end else begin
				root = root >>> 1;
			end
			b = b >>> 2;
		end
		return root;
	endfunction

	function automatic angles_t aim_angles(longint x, longint y, longint z);
		angles_t a;
		longint pan, tilt, r2, h, d2, e2, alpha, beta;
		pan = (vector_angle(y, x) + 128) >>> 8;
		if (pan > 46080) pan = 46080;
		if (pan < -46080) pan = -46080;
		r2 = x * x + y * y;
		h = neck_h - z;
		d2 = r2 + h * h;
		alpha = vector_angle(int_sqrt(r2), h);
		e2 = eye_off * eye_off;
		a.dom_err = 0;
		if (d2 > e2) begin
			beta = vector_angle(int_sqrt(d2 - e2), eye_off);
		end else begin
			beta = 0;
			a.dom_err = 1;
		end
		tilt = (alpha + beta - 180 * 65536 + 128) >>> 8;
		a.clamped = 0;
		if (tilt < tilt_floor) begin
			tilt = tilt_floor;
			a.clamped = 1;
		end
		a.pan = pan[16:0];
		a.tilt = tilt[16:0];
		return a;
	endfunction

	task automatic send_point(longint x, longint y, longint z);
		int gap;
		in_valid <= 1;
		target_x <= x[19:0];
		target_y <= y[19:0];
		target_z <= z[19:0];
		do @(posedge clk); while (in_stall);
		expected_angles.push_back(aim_angles(x, y, z));
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(20);
			gap = $urandom_range(gap_max);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		in_valid <= 0;
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	task automatic write_reg(lapt_pkg::cfg_reg_t idx, longint val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val[16:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			lapt_pkg::REG_NECK_HEIGHT: neck_h = val & 16'hFFFF;
			lapt_pkg::REG_EYE_OFFSET:  eye_off = val & 12'hFFF;
			lapt_pkg::REG_TILT_LIMIT:  tilt_floor = longint'($signed(val[16:0]));
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic longint rand_coord();
		case ($urandom_range(5))
			0: return longint'($signed(20'($urandom)));
			1: return longint'($urandom_range(2000)) - 1000;
			2: return longint'($urandom_range(40000)) - 20000;
			3: return $urandom_range(1) ? 524287 : -524288;
			default: return longint'($urandom_range(200000)) - 100000;
		endcase
	endfunction

	task automatic send_random(int n);
		longint x, y, z, e;
		repeat (n) begin
			x = rand_coord();
			y = rand_coord();
			z = rand_coord();
			if ($urandom_range(9) == 0) begin
				// near the eye ball: hits the out-of-range acos case
				e = eye_off / 2 + 1;
				x = longint'($urandom_range(2 * e)) - e;
				y = longint'($urandom_range(2 * e)) - e;
				z = neck_h - (longint'($urandom_range(2 * e)) - e);
			end else if ($urandom_range(9) == 0) begin
				z = neck_h + longint'($urandom_range(200000)) - 100000;
			end
			if (z > 524287) z = 524287;
			if (z < -524288) z = -524288;
			send_point(x, y, z);
		end
	endtask

	task automatic test_directed();
		gap_max = 0;
		stall_pct = 0;
		send_point(0, 0, 0);
		send_point(0, 0, neck_h);
		send_point(524287, 524287, 524287);
		send_point(-524288, -524288, -524288);
		send_point(-524288, 0, 0);
		send_point(-524288, -1, 0);
		send_point(-524288, 1, 11300);
		send_point(0, -524288, 0);
		send_point(0, 524287, 0);
		send_point(-5, 0, 0);
		send_point(0, -5, 0);
		send_point(100, 100, neck_h - 50);
		send_point(0, 0, neck_h + 480);
		send_point(0, 0, neck_h + 481);
		send_point(1000, 0, -524288);
		send_point(10, 10, -524288);
		send_point(524287, -524288, 524287);
		send_point(-1, -1, -1);
		send_point(1, 0, 0);
		send_point(-524288, 524287, 524287);
		settle();
	endtask

	task automatic test_register_sweep();
		longint necks[4] = '{0, 65535, 11300, 30000};
		longint eyes[4] = '{0, 4095, 480, 1};
		longint floors[4] = '{-46080, 23040, -12032, 0};
		gap_max = 3;
		stall_pct = 30;
		write_reg(lapt_pkg::REG_NONE, 17'h1ABCD);
		send_random(40);
		settle();
		for (int k = 0; k < 4; k++) begin
			write_reg(lapt_pkg::REG_NECK_HEIGHT, necks[k]);
			write_reg(lapt_pkg::REG_EYE_OFFSET, eyes[k]);
			write_reg(lapt_pkg::REG_TILT_LIMIT, floors[k]);
			send_random(100);
			settle();
		end
	endtask

	task automatic test_backpressure();
		gap_max = 0;
		stall_pct = 0;
		hold_req = 400;
		send_random(200);
		stall_pct = 90;
		send_random(100);
		settle();
	endtask

	task automatic test_random_mix();
		for (int k = 0; k < 6; k++) begin
			gap_max = (k % 3) * 4;
			stall_pct = (k % 2) ? 50 : 0;
			write_reg(lapt_pkg::REG_NECK_HEIGHT, $urandom_range(65535));
			write_reg(lapt_pkg::REG_EYE_OFFSET, $urandom_range(4095));
			write_reg(lapt_pkg::REG_TILT_LIMIT, longint'($urandom_range(69120)) - 46080);
			send_random(200);
			settle();
		end
	endtask

	always @(posedge clk) begin
		if (hold_req > 0) begin
			out_stall <= 1;
			hold_req <= hold_req - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		angles_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_angles.size() == 0) begin
				errors++;
				$display("%0t: unexpected result pan %0d tilt %0d", $time,
					pan_angle, tilt_angle);
			end else begin
				e = expected_angles.pop_front();
				n_checked++;
				n_clamped += e.clamped;
				n_domain += e.dom_err;
				if (pan_angle !== e.pan) begin
					errors++;
					$display("%0t: pan_angle expected %0d got %0d", $time, e.pan, pan_angle);
				end
				if (tilt_angle !== e.tilt) begin
					errors++;
					$display("%0t: tilt_angle expected %0d got %0d", $time, e.tilt,
						tilt_angle);
				end
				if (tilt_clamped !== e.clamped) begin
					errors++;
					$display("%0t: tilt_clamped expected %0b got %0b", $time, e.clamped,
						tilt_clamped);
				end
				if (domain_error !== e.dom_err) begin
					errors++;
					$display("%0t: domain_error expected %0b got %0b", $time, e.dom_err,
						domain_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_register_sweep();
		test_backpressure();
		test_random_mix();
		$display("sent %0d targets, checked %0d results (%0d clamped, %0d too close)",
			n_sent, n_checked, n_clamped, n_domain);
		$display("register extremes, long output hold-off and random gaps covered");
		if (errors == 0 && expected_angles.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
